// ===== rtl/uvs_pkg.sv =====
// shared constants, types and functions of the uv sphere vertex generator
`default_nettype none
package uvs_pkg;

  // fixed field widths
  localparam int unsigned GRID_W      = 10;
  localparam int unsigned RADIUS_W    = 16;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 1;

  // parameter defaults
  localparam int unsigned INDEX_BITS_DEF   = 10;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // register reset values and radius limit
  localparam logic [GRID_W-1:0]   GRID_RESET   = 10'd40;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd16384;
  localparam logic [RADIUS_W-1:0] RADIUS_MAX   = 16'd32768;

  // cordic datapath widths and start vector (inverse gain, Q2.30)
  localparam int unsigned XY_W = 34;
  localparam int unsigned Z_W  = 33;
  localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRID_DIVISIONS = 1'b0,
    REG_SPHERE_RADIUS  = 1'b1
  } cfg_reg_t;

  // one cordic lane
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rot_t;

  // arctan of 2^-k in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int k);
    logic [31:0] a;
    case (k)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // one rotation step, shift fixed per stage
  function automatic rot_t rot_step(input rot_t a, input int k);
    rot_t o;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  t;
    dx = a.y >>> k;
    dy = a.x >>> k;
    t  = $signed({1'b0, atan_turn(k)});
    if (!a.z[Z_W-1]) begin
      o.x = a.x - dx;
      o.y = a.y + dy;
      o.z = a.z - t;
    end else begin
      o.x = a.x + dx;
      o.y = a.y - dy;
      o.z = a.z + t;
    end
    return o;
  endfunction

  // latitude offset of each corner
  function automatic logic corner_dm(input logic [2:0] k);
    logic d;
    case (k)
      3'd2, 3'd4, 3'd5: d = 1'b1;
      default:          d = 1'b0;
    endcase
    return d;
  endfunction

  // longitude offset of each corner
  function automatic logic corner_dn(input logic [2:0] k);
    logic d;
    case (k)
      3'd1, 3'd2, 3'd4: d = 1'b1;
      default:          d = 1'b0;
    endcase
    return d;
  endfunction

  // round Q45 to Q15 and saturate
  function automatic logic [COORD_W-1:0] sat_q15(input logic signed [50:0] v);
    logic signed [50:0] s;
    logic signed [20:0] t;
    logic [COORD_W-1:0] o;
    s = v + 51'sd536870912;
    t = 21'(s >>> 30);
    if (t > 21'sd32767)       o = 16'h7fff;
    else if (t < -21'sd32768) o = 16'h8000;
    else                      o = t[COORD_W-1:0];
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/uvs_in_if.sv =====
// cell input channel
`default_nettype none
interface uvs_in_if #(
  parameter int unsigned INDEX_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] lat_index;
  logic [INDEX_BITS-1:0] long_index;

  modport source (output valid, lat_index, long_index, input ready);
  modport sink   (input valid, lat_index, long_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/uvs_out_if.sv =====
// vertex result channel
`default_nettype none
interface uvs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] pos_z;
  logic [15:0] tex_s;
  logic [15:0] tex_t;
  logic        last_vertex;

  modport source (output valid, pos_x, pos_y, pos_z, tex_s, tex_t, last_vertex,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_s, tex_t, last_vertex,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/uv_sphere_vertex_generator.sv =====
// uv sphere vertex generator top level: corner sequencer and vertex pipeline
//
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | lat_index, long_index (INDEX_BITS each)
//  out_ch   | out | valid/ready   | pos_x/y/z, tex_s, tex_t, last_vertex
//  cfg_*    | in  | cfg_we        | cfg_index, cfg_data (16 bits)
//
// a cell has six corners: the sequencer issues one corner per cycle while the
// pipeline advances, so the output channel runs one vertex per cycle while
// out_ch.ready holds high. corners pass the bit-per-stage phase dividers and
// the cordic stages. rst_n clears valid bits and the sequencer. a low out_ch.ready
// with valid set freezes every stage at once; nothing is lost or repeated.
`default_nettype none
module uv_sphere_vertex_generator
  import uvs_pkg::*;
#(
  parameter int unsigned INDEX_BITS   = INDEX_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  uvs_in_if.sink                      in_ch,
  uvs_out_if.source                   out_ch,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned CI_W = INDEX_BITS + 1;   // corner index width
  localparam int unsigned NW   = INDEX_BITS + 34;  // dividend width

  typedef struct packed {
    logic [GRID_W-1:0] rem;
    logic [NW-1:0]     nq;
  } div_t;

  typedef struct packed {
    rot_t        a;
    rot_t        b;
    logic [1:0]  qa;
    logic [1:0]  qb;
    logic [15:0] ts;
    logic [15:0] tt;
  } cor_t;

  // configuration registers
  logic [GRID_W-1:0]   grid_r;
  logic [RADIUS_W-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r   <= GRID_RESET;
      radius_r <= RADIUS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_DIVISIONS: grid_r   <= cfg_data[GRID_W-1:0];
        REG_SPHERE_RADIUS:  radius_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective divisor and radius
  logic [GRID_W-1:0] pe;
  logic signed [16:0] rad;
  assign pe  = (grid_r == '0) ? GRID_W'(1) : grid_r;
  assign rad = (radius_r > RADIUS_MAX) ? 17'sd32768 : $signed({1'b0, radius_r});

  // global advance
  logic en;
  logic ov_r;
  assign en = !ov_r || out_ch.ready;

  // corner sequencer
  logic                  busy_r;
  logic [2:0]            cnt_r;
  logic [INDEX_BITS-1:0] lat_r;
  logic [INDEX_BITS-1:0] long_r;
  logic                  take;

  assign in_ch.ready = en && (!busy_r || cnt_r == 3'd5);
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (en) begin
      if (take) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r && cnt_r == 3'd5) begin
        busy_r <= 1'b0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      lat_r  <= in_ch.lat_index;
      long_r <= in_ch.long_index;
    end
  end

  // corner indices and dividends
  logic [CI_W-1:0] cm;
  logic [CI_W-1:0] cn;
  logic [NW-1:0]   half;
  div_t            d0 [4];

  assign cm   = CI_W'(lat_r) + CI_W'(corner_dm(cnt_r));
  assign cn   = CI_W'(long_r) + CI_W'(corner_dn(cnt_r));
  assign half = NW'(pe >> 1);

  always_comb begin
    d0[0].rem = '0;
    d0[0].nq  = (NW'(cm) << 31) + half;
    d0[1].rem = '0;
    d0[1].nq  = (NW'(cn) << 32) + half;
    d0[2].rem = '0;
    d0[2].nq  = (NW'(cn) << 15) + half;
    d0[3].rem = '0;
    d0[3].nq  = (NW'(cm) << 15) + half;
  end

  // restoring divide, one quotient bit per stage
  function automatic div_t div_step(input div_t a, input logic [GRID_W-1:0] p);
    div_t o;
    logic [GRID_W:0] sh;
    logic            ge;
    sh    = {a.rem, a.nq[NW-1]};
    ge    = sh >= {1'b0, p};
    o.rem = ge ? GRID_W'(sh - {1'b0, p}) : sh[GRID_W-1:0];
    o.nq  = {a.nq[NW-2:0], ge};
    return o;
  endfunction

  div_t dr_r [0:NW][4];
  logic dv_r [0:NW];
  logic dl_r [0:NW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= (cnt_r == 3'd5);
      for (int l = 0; l < 4; l++) begin
        dr_r[0][l] <= d0[l];
      end
    end
  end

  for (genvar s = 0; s < NW; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[s+1] <= 1'b0;
      end else if (en) begin
        dv_r[s+1] <= dv_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dl_r[s+1] <= dl_r[s];
        for (int l = 0; l < 4; l++) begin
          dr_r[s+1][l] <= div_step(dr_r[s][l], pe);
        end
      end
    end
  end

  // phases into cordic start vectors, textures from quotients
  function automatic logic [15:0] tex_of(input logic [NW-1:0] q);
    logic [15:0] t;
    if (|q[NW-1:15]) t = '0;
    else             t = 16'd32768 - {1'b0, q[14:0]};
    return t;
  endfunction

  cor_t c0;
  always_comb begin
    c0.a.x = CORDIC_X0;
    c0.a.y = '0;
    c0.a.z = $signed({3'b000, dr_r[NW][0].nq[29:0]});
    c0.qa  = dr_r[NW][0].nq[31:30];
    c0.b.x = CORDIC_X0;
    c0.b.y = '0;
    c0.b.z = $signed({3'b000, dr_r[NW][1].nq[29:0]});
    c0.qb  = dr_r[NW][1].nq[31:30];
    c0.ts  = tex_of(dr_r[NW][2].nq);
    c0.tt  = tex_of(dr_r[NW][3].nq);
  end

  cor_t cr_r [0:CORDIC_STEPS];
  logic cv_r [0:CORDIC_STEPS];
  logic cl_r [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (en) begin
      cv_r[0] <= dv_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cr_r[0] <= c0;
      cl_r[0] <= dl_r[NW];
    end
  end

  // cordic rotation stages
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cor
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[k+1] <= 1'b0;
      end else if (en) begin
        cv_r[k+1] <= cv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cr_r[k+1].a  <= rot_step(cr_r[k].a, k);
        cr_r[k+1].b  <= rot_step(cr_r[k].b, k);
        cr_r[k+1].qa <= cr_r[k].qa;
        cr_r[k+1].qb <= cr_r[k].qb;
        cr_r[k+1].ts <= cr_r[k].ts;
        cr_r[k+1].tt <= cr_r[k].tt;
        cl_r[k+1]    <= cl_r[k];
      end
    end
  end

  // quadrant fold
  function automatic logic signed [63:0] fold(input rot_t v, input logic [1:0] q);
    logic signed [31:0] sn;
    logic signed [31:0] cs;
    logic signed [XY_W-1:0] nx;
    logic signed [XY_W-1:0] ny;
    nx = -v.x;
    ny = -v.y;
    case (q)
      2'd0:    begin cs = 32'(v.x); sn = 32'(v.y); end
      2'd1:    begin cs = 32'(ny);  sn = 32'(v.x); end
      2'd2:    begin cs = 32'(nx);  sn = 32'(ny);  end
      default: begin cs = 32'(v.y); sn = 32'(nx);  end
    endcase
    return {sn, cs};
  endfunction

  logic signed [63:0] fa;
  logic signed [63:0] fb;
  assign fa = fold(cr_r[CORDIC_STEPS].a, cr_r[CORDIC_STEPS].qa);
  assign fb = fold(cr_r[CORDIC_STEPS].b, cr_r[CORDIC_STEPS].qb);

  logic signed [31:0] sa_r, ca_r, sb_r, cb_r;
  logic [15:0]        qts_r, qtt_r;
  logic               qv_r, ql_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r <= 1'b0;
    end else if (en) begin
      qv_r <= cv_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r  <= fa[63:32];
      ca_r  <= fa[31:0];
      sb_r  <= fb[63:32];
      cb_r  <= fb[31:0];
      qts_r <= cr_r[CORDIC_STEPS].ts;
      qtt_r <= cr_r[CORDIC_STEPS].tt;
      ql_r  <= cl_r[CORDIC_STEPS];
    end
  end

  // first products
  logic signed [63:0] pss_r, psc_r;
  logic signed [50:0] pcr_r;
  logic [15:0]        mts_r, mtt_r;
  logic               mv_r, ml_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (en) begin
      mv_r <= qv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pss_r <= sa_r * sb_r;
      psc_r <= sa_r * cb_r;
      pcr_r <= 51'(ca_r) * 51'(rad);
      mts_r <= qts_r;
      mtt_r <= qtt_r;
      ml_r  <= ql_r;
    end
  end

  // scale by radius
  logic signed [33:0] tss;
  logic signed [33:0] tsc;
  assign tss = 34'(pss_r >>> 30);
  assign tsc = 34'(psc_r >>> 30);

  logic signed [50:0] vx_r, vy_r, vz_r;
  logic [15:0]        nts_r, ntt_r;
  logic               nv_r, nl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= 1'b0;
    end else if (en) begin
      nv_r <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r  <= 51'(tss) * 51'(rad);
      vz_r  <= 51'(tsc) * 51'(rad);
      vy_r  <= pcr_r;
      nts_r <= mts_r;
      ntt_r <= mtt_r;
      nl_r  <= ml_r;
    end
  end

  // rounding and output register
  logic [15:0] ox_r, oy_r, oz_r, ots_r, ott_r;
  logic        ol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= nv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r  <= sat_q15(vx_r);
      oy_r  <= sat_q15(vy_r);
      oz_r  <= sat_q15(vz_r);
      ots_r <= nts_r;
      ott_r <= ntt_r;
      ol_r  <= nl_r;
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.pos_x       = ox_r;
  assign out_ch.pos_y       = oy_r;
  assign out_ch.pos_z       = oz_r;
  assign out_ch.tex_s       = ots_r;
  assign out_ch.tex_t       = ott_r;
  assign out_ch.last_vertex = ol_r;

endmodule
`default_nettype wire
